@@ sv/wft_pkg.sv @@
// ----------------------------------------------------------------------------
// wft_pkg
// shared types, constants, the word folding function and the count field
// helper of the word frequency table
// ----------------------------------------------------------------------------
package wft_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int COUNT_WIDTH = 16;
  localparam int WORD_W      = 120;
  localparam int WORD_BYTES  = 15;
  localparam int HIGH_W      = 64;
  localparam int LOW_W       = 56;
  localparam int OUT_COUNT_W = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [7:0] CHAR_UP_A = 8'h41;
  localparam logic [7:0] CHAR_UP_Z = 8'h5a;
  localparam logic [7:0] CHAR_LO_A = 8'h61;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_COUNT = 2'd1,
    CMD_LIST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INCREMENTED = 3'd0,
    ST_INSERTED    = 3'd1,
    ST_FULL        = 3'd2,
    ST_LIST_ENTRY  = 3'd3,
    ST_LIST_EMPTY  = 3'd4,
    ST_CLEARED     = 3'd5
  } status_t;

  // one classified item travelling from front to back
  typedef struct packed {
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
  } item_t;

  // fold A-Z to lower case, zero every byte after the first zero byte
  function automatic logic [WORD_W-1:0] fold_word(input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] r;
    logic              ended;
    logic [7:0]        b;
    r     = '0;
    ended = 1'b0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      b = w[WORD_W-1-8*i -: 8];
      if (b == 8'h00) begin
        ended = 1'b1;
      end
      if (ended) begin
        b = 8'h00;
      end
      if (b >= CHAR_UP_A && b <= CHAR_UP_Z) begin
        b = b - CHAR_UP_A + CHAR_LO_A;
      end
      r[WORD_W-1-8*i -: 8] = b;
    end
    return r;
  endfunction

  // low bits of a count, zero extended when the count is narrow
  function automatic logic [OUT_COUNT_W-1:0] count_field(
      input logic [COUNT_WIDTH-1:0] c);
    logic [COUNT_WIDTH+OUT_COUNT_W-1:0] ext;
    ext = {{OUT_COUNT_W{1'b0}}, c};
    return ext[OUT_COUNT_W-1:0];
  endfunction

endpackage

@@ sv/wft_front.sv @@
// ----------------------------------------------------------------------------
// wft_front
// accepts input transactions, folds the word and drops unused commands
// ----------------------------------------------------------------------------
module wft_front (
  input  logic                       push,
  input  logic                       full,
  input  logic [1:0]                 in_cmd,
  input  logic [wft_pkg::HIGH_W-1:0] in_word_high,
  input  logic [wft_pkg::LOW_W-1:0]  in_word_low,
  output logic                       q_push,
  output wft_pkg::item_t             q_item
);

  logic accept;

  assign accept = push && !full;

  // an unused command is accepted and then forgotten
  assign q_push      = accept && (wft_pkg::cmd_t'(in_cmd) != wft_pkg::CMD_NONE);
  assign q_item.cmd  = wft_pkg::cmd_t'(in_cmd);
  assign q_item.word = wft_pkg::fold_word({in_word_high, in_word_low});

endmodule

@@ sv/wft_queue.sv @@
// ----------------------------------------------------------------------------
// wft_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module wft_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_push,
  input  wft_pkg::item_t q_item,
  input  logic           q_pop,
  output logic           q_full,
  output logic           q_valid,
  output wft_pkg::item_t q_head
);

  localparam int PTR_W = (wft_pkg::QUEUE_DEPTH > 1) ? $clog2(wft_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(wft_pkg::QUEUE_DEPTH + 1);

  wft_pkg::item_t   slot_r [wft_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_full  = (cnt_r == CNT_W'(wft_pkg::QUEUE_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_head  = slot_r[rd_ptr_r];
  assign do_push = q_push && !q_full;
  assign do_pop  = q_pop && q_valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(wft_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= q_item;
    end
  end

endmodule

@@ sv/wft_back.sv @@
// ----------------------------------------------------------------------------
// wft_back
// word table with parallel lookup, count update, listing and result register
// ----------------------------------------------------------------------------
module wft_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  wft_pkg::item_t                  q_head,
  output logic                            q_pop,
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      out_status,
  output logic [wft_pkg::HIGH_W-1:0]      out_word_high,
  output logic [wft_pkg::LOW_W-1:0]       out_word_low,
  output logic [wft_pkg::OUT_COUNT_W-1:0] out_count,
  output logic                            out_last
);

  localparam int IDX_W  = wft_pkg::IDX_W;
  localparam int FILL_W = wft_pkg::FILL_W;
  localparam int CW     = wft_pkg::COUNT_WIDTH;
  localparam int WW     = wft_pkg::WORD_W;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_UPDATE = 3'b010,
    S_LIST   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [WW-1:0] word_r  [wft_pkg::TABLE_DEPTH];
  logic [CW-1:0] count_r [wft_pkg::TABLE_DEPTH];

  logic [FILL_W-1:0]              fill_r, fill_nxt;
  logic [IDX_W-1:0]               list_idx_r, list_idx_nxt;
  logic [WW-1:0]                  cur_word_r;
  logic [wft_pkg::TABLE_DEPTH-1:0] hit_r;
  logic [wft_pkg::TABLE_DEPTH-1:0] hit_vec;

  logic             out_valid_r, out_valid_nxt;
  wft_pkg::status_t out_status_r, res_status;
  logic [WW-1:0]    out_word_r, res_word;
  logic [wft_pkg::OUT_COUNT_W-1:0] out_count_r, res_count;
  logic             out_last_r, res_last;
  logic             res_load, out_ready;

  logic             hit_any;
  logic [IDX_W-1:0] hit_idx;
  logic [CW-1:0]    hit_count, inc_count;
  logic             table_full;

  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_word;
  logic [CW-1:0]    wr_count;

  assign out_ready = !out_valid_r || pop;
  assign table_full = (fill_r == FILL_W'(wft_pkg::TABLE_DEPTH));

  // parallel compare of the queue head against every valid entry
  always_comb begin
    for (int i = 0; i < wft_pkg::TABLE_DEPTH; i++) begin
      hit_vec[i] = (FILL_W'(i) < fill_r) && (word_r[i] == q_head.word);
    end
  end

  // stored words are distinct, so at most one bit of hit_r is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < wft_pkg::TABLE_DEPTH; i++) begin
      hit_idx = hit_idx | (hit_r[i] ? IDX_W'(i) : '0);
    end
  end

  assign hit_any   = |hit_r;
  assign hit_count = count_r[hit_idx];
  assign inc_count = (hit_count == wft_pkg::COUNT_MAX) ? hit_count : hit_count + CW'(1);

  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    list_idx_nxt = list_idx_r;
    q_pop        = 1'b0;
    res_load     = 1'b0;
    res_status   = wft_pkg::ST_CLEARED;
    res_word     = '0;
    res_count    = '0;
    res_last     = 1'b1;
    wr_en        = 1'b0;
    wr_idx       = fill_r[IDX_W-1:0];
    wr_word      = 1'b0;
    wr_count     = CW'(1);

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          unique case (q_head.cmd)
            wft_pkg::CMD_CLEAR: begin
              if (out_ready) begin
                q_pop    = 1'b1;
                fill_nxt = '0;
                res_load = 1'b1;
              end
            end
            wft_pkg::CMD_COUNT: begin
              q_pop     = 1'b1;
              state_nxt = S_UPDATE;
            end
            wft_pkg::CMD_LIST: begin
              q_pop        = 1'b1;
              list_idx_nxt = '0;
              state_nxt    = S_LIST;
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      S_UPDATE: begin
        if (out_ready) begin
          res_load  = 1'b1;
          res_word  = cur_word_r;
          state_nxt = S_IDLE;
          priority if (hit_any) begin
            res_status = wft_pkg::ST_INCREMENTED;
            res_count  = wft_pkg::count_field(inc_count);
            wr_en      = 1'b1;
            wr_idx     = hit_idx;
            wr_count   = inc_count;
          end else if (table_full) begin
            res_status = wft_pkg::ST_FULL;
          end else begin
            res_status = wft_pkg::ST_INSERTED;
            res_count  = wft_pkg::count_field(CW'(1));
            wr_en      = 1'b1;
            wr_word    = 1'b1;
            fill_nxt   = fill_r + FILL_W'(1);
          end
        end
      end
      S_LIST: begin
        if (out_ready) begin
          res_load = 1'b1;
          if (fill_r == '0) begin
            res_status = wft_pkg::ST_LIST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            res_status   = wft_pkg::ST_LIST_ENTRY;
            res_word     = word_r[list_idx_r];
            res_count    = wft_pkg::count_field(count_r[list_idx_r]);
            res_last     = (FILL_W'(list_idx_r) + FILL_W'(1) == fill_r);
            list_idx_nxt = list_idx_r + IDX_W'(1);
            if (res_last) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_idx_r <= list_idx_nxt;
    if (state_r == S_IDLE && q_valid) begin
      cur_word_r <= q_head.word;
      hit_r      <= hit_vec;
    end
    if (wr_en) begin
      count_r[wr_idx] <= wr_count;
      if (wr_word) begin
        word_r[wr_idx] <= cur_word_r;
      end
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_word_r   <= res_word;
      out_count_r  <= res_count;
      out_last_r   <= res_last;
    end
  end

  assign empty         = !out_valid_r;
  assign out_status    = out_status_r;
  assign out_word_high = out_word_r[WW-1 -: wft_pkg::HIGH_W];
  assign out_word_low  = out_word_r[wft_pkg::LOW_W-1:0];
  assign out_count     = out_count_r;
  assign out_last      = out_last_r;

endmodule

@@ sv/word_frequency_table_top.sv @@
// ----------------------------------------------------------------------------
// word_frequency_table_top
// table of distinct lower-cased words with occurrence counts
// ----------------------------------------------------------------------------
// usage
//   input side is a queue: drive in_cmd and the word, raise push; a
//   transaction is taken at a rising edge with push high and full low
//   result side is a queue: while empty is low the oldest result sits on
//   out_*; raise pop to take it. out_last marks the final result of an item
//   clear and count items give one result, a list item one per entry
//   (or one list-empty result), command 3 gives none
//   an item passes the item queue, then the registered compare, then the
//   result register on its way to out_*; a clear item goes from the item
//   queue straight to the result register. the back end works on one item
//   at a time: a count item takes a compare step, then an update step, a
//   clear one step, a list a start step, then one read per entry
//   the two-entry item queue keeps input flowing while the back end works
//   and a result register lets a finished result wait while new input
//   transactions are taken
//   reset empties the table, the item queue and the result register
//   when pop stays low the result register holds, the back end stops and
//   full rises once the item queue fills up
// ----------------------------------------------------------------------------
module word_frequency_table_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            push,
  output logic                            full,
  input  logic [1:0]                      in_cmd,
  input  logic [wft_pkg::HIGH_W-1:0]      in_word_high,
  input  logic [wft_pkg::LOW_W-1:0]       in_word_low,
  // result channel
  output logic                            empty,
  input  logic                            pop,
  output logic [2:0]                      out_status,
  output logic [wft_pkg::HIGH_W-1:0]      out_word_high,
  output logic [wft_pkg::LOW_W-1:0]       out_word_low,
  output logic [wft_pkg::OUT_COUNT_W-1:0] out_count,
  output logic                            out_last
);

  // front to queue
  logic           q_push;
  wft_pkg::item_t q_item;

  // queue to back
  logic           q_pop;
  logic           q_full;
  logic           q_valid;
  wft_pkg::item_t q_head;

  // input side stalls only when the item queue is full
  assign full = q_full;

  // fold and classify
  wft_front u_front (
    .push         (push),
    .full         (q_full),
    .in_cmd       (in_cmd),
    .in_word_high (in_word_high),
    .in_word_low  (in_word_low),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  // decouples front from back
  wft_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .q_full  (q_full),
    .q_valid (q_valid),
    .q_head  (q_head)
  );

  // table lookup, update, listing and result register
  wft_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_status    (out_status),
    .out_word_high (out_word_high),
    .out_word_low  (out_word_low),
    .out_count     (out_count),
    .out_last      (out_last)
  );

endmodule

@@ bench/tb_word_frequency_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_word_frequency_table_top
// self-checking bench for the word frequency table: a directed table of
// items, a fill-to-full phase and a random phase, every result compared in
// order against hand-written results or a local model of the table
// ----------------------------------------------------------------------------
module tb_word_frequency_table_top;
  import wft_pkg::*;

  // idle chance in percent at each try, on each side
  localparam int IDLE_PCT      = 13;
  // receiver hold-off long enough to fill the item queue and stall push
  localparam int HOLD_CYCLES   = 300;
  // longest correct stretch without a transaction is the hold-off plus a
  // list drain; several times that
  localparam int STALL_LIMIT   = 2000;
  // quiet cycles after the last result
  localparam int SETTLE_CYCLES = 20;
  localparam int RANDOM_ITEMS  = 55;
  localparam int POOL_SIZE     = 40;
  localparam int DIR_ROWS      = 20;

  logic                   clk;
  logic                   rst_n;
  logic                   push;
  logic                   full;
  logic [1:0]             in_cmd;
  logic [HIGH_W-1:0]      in_word_high;
  logic [LOW_W-1:0]       in_word_low;
  logic                   empty;
  logic                   pop;
  logic [2:0]             out_status;
  logic [HIGH_W-1:0]      out_word_high;
  logic [LOW_W-1:0]       out_word_low;
  logic [OUT_COUNT_W-1:0] out_count;
  logic                   out_last;

  word_frequency_table_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_cmd        (in_cmd),
    .in_word_high  (in_word_high),
    .in_word_low   (in_word_low),
    .empty         (empty),
    .pop           (pop),
    .out_status    (out_status),
    .out_word_high (out_word_high),
    .out_word_low  (out_word_low),
    .out_count     (out_count),
    .out_last      (out_last)
  );

  // one result transaction as seen on the out_ ports
  typedef struct {
    status_t                st;
    logic [HIGH_W-1:0]      hi;
    logic [LOW_W-1:0]       lo;
    logic [OUT_COUNT_W-1:0] cnt;
    logic                   last;
  } result_t;

  // directed stimulus row; typed rows carry their single result by hand
  typedef struct {
    cmd_t              cmd;
    logic [WORD_W-1:0] word;
    bit                typed;
    status_t           st;
    logic [WORD_W-1:0] folded;
    int unsigned       cnt;
  } row_t;

  row_t dir_rows [DIR_ROWS] = '{
    // list and clear straight after reset
    '{CMD_LIST,  '0,                              1'b1, ST_LIST_EMPTY,  '0, 0},
    '{CMD_CLEAR, {"junk", 88'd0},                 1'b1, ST_CLEARED,     '0, 0},
    // insert, then hit again in another case
    '{CMD_COUNT, {"HELLO", 80'd0},                1'b1, ST_INSERTED,
      {"hello", 80'd0}, 1},
    '{CMD_COUNT, {"hello", 80'd0},                1'b1, ST_INCREMENTED,
      {"hello", 80'd0}, 2},
    // garbage after the terminator does not make a new word
    '{CMD_COUNT, {"HeLLo", 8'h00, "xyz", 48'd0},  1'b1, ST_INCREMENTED,
      {"hello", 80'd0}, 3},
    // empty word, with and without trailing garbage
    '{CMD_COUNT, '0,                              1'b1, ST_INSERTED,    '0, 1},
    '{CMD_COUNT, {8'h00, "EMPTY", 72'd0},         1'b1, ST_INCREMENTED, '0, 2},
    // a lone dot is a plain word
    '{CMD_COUNT, {".", 112'd0},                   1'b1, ST_INSERTED,
      {".", 112'd0}, 1},
    // all-ones word: no byte is a letter, nothing folds
    '{CMD_COUNT, {WORD_W{1'b1}},                  1'b1, ST_INSERTED,
      {WORD_W{1'b1}}, 1},
    '{CMD_COUNT, "ABCDEFGHIJKLMNO",               1'b0, ST_INCREMENTED, '0, 0},
    '{CMD_COUNT, "abcdefghijklmnO",               1'b0, ST_INCREMENTED, '0, 0},
    // bytes at and just outside A..Z and a..z
    '{CMD_COUNT, {"@AZ[`az{", 56'd0},             1'b0, ST_INCREMENTED, '0, 0},
    // unused command gives nothing
    '{CMD_NONE,  {"HELLO", 80'd0},                1'b0, ST_INCREMENTED, '0, 0},
    '{CMD_COUNT, {"HELLO", 80'd0},                1'b0, ST_INCREMENTED, '0, 0},
    '{CMD_LIST,  '0,                              1'b0, ST_INCREMENTED, '0, 0},
    '{CMD_COUNT, {8'h80, "Z", 8'h7f, 8'h01, 88'd0}, 1'b0, ST_INCREMENTED, '0, 0},
    '{CMD_CLEAR, '0,                              1'b1, ST_CLEARED,     '0, 0},
    '{CMD_LIST,  {WORD_W{1'b1}},                  1'b1, ST_LIST_EMPTY,  '0, 0},
    // counting restarts after a clear
    '{CMD_COUNT, {"hello", 80'd0},                1'b1, ST_INSERTED,
      {"hello", 80'd0}, 1},
    '{CMD_LIST,  '0,                              1'b0, ST_INCREMENTED, '0, 0}
  };

  // local copy of the table
  logic [WORD_W-1:0]      vocab_words  [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0] vocab_counts [TABLE_DEPTH];
  int                     vocab_fill;

  result_t step_results[$];      // results of the item just accepted
  result_t awaited_results[$];   // results not yet seen on the out_ ports
  int      mismatches;
  bit      quiet;                // no idling on either side
  int      holds_asked;
  int      holds_served;

  // ------------------------------------------------------------------------
  // model of the table
  // ------------------------------------------------------------------------

  // lower-case A..Z, zero everything from the first zero byte on
  function automatic logic [WORD_W-1:0] fold_case(input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] w;
    logic [7:0]        ch;
    bit                done;
    w    = '0;
    done = 1'b0;
    for (int k = 0; k < WORD_BYTES; k++) begin
      ch   = raw[WORD_W-1-8*k -: 8];
      done = done || (ch == 8'h00);
      if (done) begin
        ch = 8'h00;
      end else if (ch >= CHAR_UP_A && ch <= CHAR_UP_Z) begin
        ch = ch | 8'h20;
      end
      w[WORD_W-1-8*k -: 8] = ch;
    end
    return w;
  endfunction

  function automatic result_t mk_result(input status_t st,
                                        input logic [WORD_W-1:0] w,
                                        input logic [31:0] cnt, input bit last);
    result_t r;
    r.st   = st;
    r.hi   = w[WORD_W-1 -: HIGH_W];
    r.lo   = w[LOW_W-1:0];
    r.cnt  = cnt[OUT_COUNT_W-1:0];
    r.last = last;
    return r;
  endfunction

  // update the table for one accepted item, results into step_results
  task automatic apply_to_table(input cmd_t c, input logic [WORD_W-1:0] raw);
    logic [WORD_W-1:0] w;
    int                slot;
    step_results.delete();
    w = fold_case(raw);
    case (c)
      CMD_CLEAR: begin
        vocab_fill = 0;
        step_results.push_back(mk_result(ST_CLEARED, '0, 0, 1'b1));
      end
      CMD_COUNT: begin
        slot = -1;
        for (int i = 0; i < vocab_fill && slot < 0; i++) begin
          if (vocab_words[i] == w) begin
            slot = i;
          end
        end
        if (slot >= 0) begin
          if (vocab_counts[slot] != COUNT_MAX) begin
            vocab_counts[slot]++;
          end
          step_results.push_back(mk_result(ST_INCREMENTED, w,
                                            32'(vocab_counts[slot]), 1'b1));
        end else if (vocab_fill >= TABLE_DEPTH) begin
          step_results.push_back(mk_result(ST_FULL, w, 0, 1'b1));
        end else begin
          vocab_words[vocab_fill]  = w;
          vocab_counts[vocab_fill] = 1;
          vocab_fill++;
          step_results.push_back(mk_result(ST_INSERTED, w, 1, 1'b1));
        end
      end
      CMD_LIST: begin
        if (vocab_fill == 0) begin
          step_results.push_back(mk_result(ST_LIST_EMPTY, '0, 0, 1'b1));
        end
        for (int i = 0; i < vocab_fill; i++) begin
          step_results.push_back(mk_result(ST_LIST_ENTRY, vocab_words[i],
                                            32'(vocab_counts[i]),
                                            i == vocab_fill - 1));
        end
      end
      default: begin
        // unused command: no result, table untouched
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // sender helpers
  // ------------------------------------------------------------------------

  // offer one item; returns at the edge where it is taken
  task automatic offer(input cmd_t c, input logic [WORD_W-1:0] raw);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push         <= 1'b1;
    in_cmd       <= c;
    in_word_high <= raw[WORD_W-1 -: HIGH_W];
    in_word_low  <= raw[LOW_W-1:0];
    @(posedge clk);
    while (full) begin
      @(posedge clk);
    end
  endtask

  task automatic run_item(input cmd_t c, input logic [WORD_W-1:0] raw);
    offer(c, raw);
    apply_to_table(c, raw);
    foreach (step_results[i]) begin
      awaited_results.push_back(step_results[i]);
    end
  endtask

  // stop pushing and wait until every awaited result has come out
  task automatic drain();
    push <= 1'b0;
    do begin
      @(posedge clk);
    end while (awaited_results.size() != 0);
  endtask

  // random case on letters, random junk after the terminator now and then
  function automatic logic [WORD_W-1:0] vary_word(input logic [WORD_W-1:0] base);
    logic [WORD_W-1:0] w;
    logic [7:0]        ch;
    bit                past_end;
    bit                junk;
    w        = base;
    past_end = 1'b0;
    junk     = ($urandom_range(99) < 30);
    for (int k = 0; k < WORD_BYTES; k++) begin
      ch = base[WORD_W-1-8*k -: 8];
      if (ch == 8'h00) begin
        if (past_end && junk) begin
          ch = 8'($urandom_range(255));
        end
        past_end = 1'b1;
      end else if (ch >= 8'h61 && ch <= 8'h7a && $urandom_range(1) == 1) begin
        ch = ch & 8'hdf;
      end
      w[WORD_W-1-8*k -: 8] = ch;
    end
    return w;
  endfunction

  // word of nonzero bytes, length 0..15, or 1..15 with letters_only, which keeps it lower case
  function automatic logic [WORD_W-1:0] make_word(input bit letters_only);
    logic [WORD_W-1:0] w;
    int                len;
    w   = '0;
    len = letters_only ? $urandom_range(WORD_BYTES, 1) : $urandom_range(WORD_BYTES);
    for (int k = 0; k < len; k++) begin
      w[WORD_W-1-8*k -: 8] = letters_only ? 8'($urandom_range(8'h7a, 8'h61))
                                          : 8'($urandom_range(255, 1));
    end
    return w;
  endfunction

  // ------------------------------------------------------------------------
  // mismatch reporting and result checking
  // ------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // a result transaction is taken at an edge with pop high and empty low
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && pop && !empty) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, status %0d", out_status));
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.st) begin
          flag_mismatch($sformatf("status %0d, want %0d", out_status, want.st));
        end
        if (out_word_high !== want.hi) begin
          flag_mismatch($sformatf("word_high %h, want %h", out_word_high, want.hi));
        end
        if (out_word_low !== want.lo) begin
          flag_mismatch($sformatf("word_low %h, want %h", out_word_low, want.lo));
        end
        if (out_count !== want.cnt) begin
          flag_mismatch($sformatf("count %0d, want %0d", out_count, want.cnt));
        end
        if (out_last !== want.last) begin
          flag_mismatch($sformatf("last %b, want %b", out_last, want.last));
        end
      end
    end
  end

  // ------------------------------------------------------------------------
  // clock, receiver, watchdog
  // ------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random pop, or a long hold-off when the sender asks for one
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else begin
        pop <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ends the run when no transaction moves for too long
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) begin
        stalled = 0;
      end else begin
        stalled++;
      end
    end
    $display("word_frequency_table_top test failed");
    $finish;
  end

  // ------------------------------------------------------------------------
  // sender: reset, directed rows, full table, random items
  // ------------------------------------------------------------------------
  initial begin : sender
    logic [WORD_W-1:0] pool [POOL_SIZE];
    logic [WORD_W-1:0] raw;
    cmd_t              c;
    int                pick;
    int                counted;

    mismatches   = 0;
    quiet        = 1'b0;
    holds_asked  = 0;
    holds_served = 0;
    vocab_fill   = 0;
    rst_n        <= 1'b0;
    push         <= 1'b0;
    in_cmd       <= CMD_NONE;
    in_word_high <= '0;
    in_word_low  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows; typed rows queue their hand-written result
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].cmd, dir_rows[i].word);
      apply_to_table(dir_rows[i].cmd, dir_rows[i].word);
      if (dir_rows[i].typed) begin
        awaited_results.push_back(mk_result(dir_rows[i].st, dir_rows[i].folded,
                                            dir_rows[i].cnt, 1'b1));
      end else begin
        foreach (step_results[j]) begin
          awaited_results.push_back(step_results[j]);
        end
      end
    end

    // fill the table, overflow it twice, hit a stored word, list all 32
    run_item(CMD_CLEAR, '0);
    for (int k = 0; k < TABLE_DEPTH + 2; k++) begin
      run_item(CMD_COUNT, {"FILL", 8'(8'h30 + k), 80'd0});
    end
    run_item(CMD_COUNT, {"fill5", 80'd0});
    run_item(CMD_LIST, '0);
    run_item(CMD_CLEAR, '0);

    // random part: mostly words from a small vocabulary so counts grow
    foreach (pool[i]) begin
      pool[i] = make_word(1'b1);
    end
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      // long receiver hold-off while we keep pushing
      if (counted == 10) begin
        holds_asked++;
      end
      // let everything drain once with no input at all
      if (counted == 25) begin
        drain();
      end
      quiet = (counted >= 30 && counted < 50);

      pick = $urandom_range(99);
      if (pick < 4) begin
        c = CMD_CLEAR;
      end else if (pick < 12) begin
        c = CMD_LIST;
      end else if (pick < 15) begin
        c = CMD_NONE;
      end else begin
        c = CMD_COUNT;
      end

      pick = $urandom_range(99);
      if (pick < 70) begin
        raw = vary_word(pool[$urandom_range(POOL_SIZE - 1)]);
      end else if (pick < 85) begin
        raw = WORD_W'({$urandom, $urandom, $urandom, $urandom});
      end else begin
        raw = make_word(1'b0);
      end

      run_item(c, raw);
      if (c != CMD_NONE) begin
        counted++;
      end
    end
    quiet = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("word_frequency_table_top test passed");
    end else begin
      $display("word_frequency_table_top test failed");
    end
    $finish;
  end

endmodule
